// ===== src/b64e_pkg.sv =====
// Package for the streaming base64 encoder: request/response payload types,
// the group phase enum, the job record and the sextet-to-character mapping.
// No dependencies.
`default_nettype none

package b64e_pkg;

   // Request payload: one raw byte of the message
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   // Response payload: one output character
   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       message_end;
   } rsp_type;

   // Position within the current 3-byte group
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   // Characters one byte produces, at most four
   localparam int unsigned JOB_SLOTS   = 4;
   localparam int unsigned SLOT_W      = $clog2(JOB_SLOTS);

   // Job queue between the front and back parts
   localparam int unsigned JOB_DEPTH   = 4;
   localparam int unsigned JOB_PTR_W   = $clog2(JOB_DEPTH);
   localparam int unsigned JOB_CNT_W   = $clog2(JOB_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR     = 8'h3D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   // One classified byte: its characters, the index of the last one, final flag
   typedef struct packed {
      logic [JOB_SLOTS-1:0][7:0] chars;
      logic [SLOT_W-1:0]         last_slot;
      logic                      fin;
   } job_type;

   // Map a 6-bit sextet onto the standard base64 alphabet
   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      logic [7:0] ext;
      ext = {2'b00, s};
      if (s < 6'd26) begin
         return CHAR_UPPER_A + ext;
      end else if (s < 6'd52) begin
         return CHAR_LOWER_A + ext - 8'd26;
      end else if (s < 6'd62) begin
         return CHAR_ZERO + ext - 8'd52;
      end else if (s == 6'd62) begin
         return CHAR_PLUS;
      end else begin
         return CHAR_SLASH;
      end
   endfunction

endpackage

`default_nettype wire

// ===== src/b64e_front.sv =====
// Front part of the base64 encoder: accepts bytes, tracks the group phase and
// leftover bits, and turns each byte into a job of up to four characters.
// Depends on b64e_pkg.
`default_nettype none

module b64e_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire b64e_pkg::req_type req_data,
   input  wire logic              accept,
   output b64e_pkg::job_type      job
);
   import b64e_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] leftover_ff, leftover_in;

   logic [7:0] b;
   logic       fin;

   assign b   = req_data.data_byte;
   assign fin = req_data.final_byte;

   // Next phase and leftover bits
   always_comb begin
      phase_in    = phase_ff;
      leftover_in = leftover_ff;
      if (accept) begin
         case (phase_ff)
            PH_SECOND: begin
               phase_in    = PH_THIRD;
               leftover_in = b[3:0];
            end
            PH_THIRD: begin
               phase_in    = PH_FIRST;
               leftover_in = 4'd0;
            end
            default: begin
               phase_in    = PH_SECOND;
               leftover_in = {2'b00, b[1:0]};
            end
         endcase
         // close the group on the final byte
         if (fin) begin
            phase_in    = PH_FIRST;
            leftover_in = 4'd0;
         end
      end
   end

   // Build the job for the byte on the request port
   always_comb begin
      job.chars     = {JOB_SLOTS{PAD_CHAR}};
      job.last_slot = '0;
      job.fin       = fin;
      case (phase_ff)
         PH_SECOND: begin
            job.chars[0] = sextet_char({leftover_ff[1:0], b[7:4]});
            if (fin) begin
               job.chars[1]  = sextet_char({b[3:0], 2'b00});
               job.last_slot = SLOT_W'(2);
            end
         end
         PH_THIRD: begin
            job.chars[0]  = sextet_char({leftover_ff[3:0], b[7:6]});
            job.chars[1]  = sextet_char(b[5:0]);
            job.last_slot = SLOT_W'(1);
         end
         default: begin
            job.chars[0] = sextet_char(b[7:2]);
            if (fin) begin
               job.chars[1]  = sextet_char({b[1:0], 4'b0000});
               job.last_slot = SLOT_W'(3);
            end
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIRST;
         leftover_ff <= 4'd0;
      end else begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/b64e_job_queue.sv =====
// Short job queue between the front and back parts of the base64 encoder.
// Depends on b64e_pkg.
`default_nettype none

module b64e_job_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire b64e_pkg::job_type wr_job,
   output logic                   full,
   input  wire logic              rd_en,
   output b64e_pkg::job_type      rd_job,
   output logic                   rd_valid
);
   import b64e_pkg::*;

   job_type                entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0]   count_ff,  count_in;
   logic                   do_wr, do_rd;

   assign full     = (count_ff == JOB_CNT_W'(JOB_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_job   = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + JOB_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + JOB_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + JOB_CNT_W'(1);
      end else if (!do_wr && do_rd) begin
         count_in = count_ff - JOB_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store jobs
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

`default_nettype wire

// ===== src/b64e_back.sv =====
// Back part of the base64 encoder: walks the characters of each job and
// holds one character at a time in the response register.
// Depends on b64e_pkg.
`default_nettype none

module b64e_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire b64e_pkg::job_type job,
   input  wire logic              job_valid,
   output logic                   job_done,
   output b64e_pkg::rsp_type      rsp_data,
   output logic                   empty,
   input  wire logic              pop
);
   import b64e_pkg::*;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   logic              load;
   logic              at_last;

   assign load     = job_valid && (!out_valid_ff || pop);
   assign at_last  = (slot_ff == job.last_slot);
   assign job_done = load && at_last;
   assign rsp_data = out_ff;
   assign empty    = !out_valid_ff;

   // Pick the next character and advance the slot
   always_comb begin
      slot_in      = slot_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_in.out_char    = job.chars[slot_ff];
         out_in.run_last    = at_last;
         out_in.message_end = at_last && job.fin;
         out_valid_in       = 1'b1;
         slot_in            = at_last ? '0 : slot_ff + SLOT_W'(1);
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

// ===== src/base64_stream_encoder.sv =====
// Streaming base64 encoder; a byte goes through the job queue to the response
// register. Throughput: one character per cycle while the consumer pops, set by
// the single-character response register; a byte yields 1 to 4 characters
// (first and second byte 1, third 2, final byte 2 to 4).
// Reset is synchronous, active high; it clears the group state, the job queue
// and the response valid flag. Depends on b64e_pkg and the b64e_* modules.
`default_nettype none

module base64_stream_encoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire b64e_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output b64e_pkg::rsp_type      rsp_data
);
   import b64e_pkg::*;

   job_type front_job;
   job_type queue_job;
   logic    queue_valid;
   logic    job_done;
   logic    accept;

   assign accept = push && !full;

   // Classify incoming bytes
   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .accept   (accept),
      .job      (front_job)
   );

   // Decouple the front from the back
   b64e_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_job   (front_job),
      .full     (full),
      .rd_en    (job_done),
      .rd_job   (queue_job),
      .rd_valid (queue_valid)
   );

   // Emit characters
   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (queue_job),
      .job_valid (queue_valid),
      .job_done  (job_done),
      .rsp_data  (rsp_data),
      .empty     (empty),
      .pop       (pop)
   );

endmodule

`default_nettype wire
